// ----- hdl/gasr_pkg.sv -----
// Package for the global alignment score row unit.
// Shared types, request codes, register indexes and score constants.
// No dependencies.
package gasr_pkg;

   // Request operation codes
   localparam logic [1:0] OP_LOAD_A  = 2'd0;
   localparam logic [1:0] OP_LOAD_B  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_A_LENGTH     = 2'd0;
   localparam logic [1:0] CSR_B_LENGTH     = 2'd1;
   localparam logic [1:0] CSR_REVERSE_MODE = 2'd2;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int POS_W    = 10;
   localparam int SYM_W    = 8;
   localparam int ALEN_W   = 11;
   localparam int BLEN_W   = 6;
   localparam int CSR_W    = 11;
   localparam int COLUMN_W = 6;
   localparam int RSP_W    = 12;

   // Internal score: a_length up to 2047 plus 63 columns fits in 13 bits
   localparam int SCORE_W = 13;
   typedef logic signed [SCORE_W-1:0] score_type;

   // Match bonus and gap/mismatch penalty magnitude
   localparam score_type SCORE_ONE = score_type'(1);

   localparam score_type RSP_MAX = score_type'(2047);
   localparam score_type RSP_MIN = score_type'(-2048);

   // Controller state
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW,
      ST_CELL,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_a;     // write request symbol into store A
      logic load_b;     // write request symbol into store B
      logic init_wr;    // write initial row entry -col
      logic row_start;  // open a new row: entry 0, left/diag seeds, fetch A
      logic cell_en;    // compute one cell at col
      logic rd_en;      // read row and B store at rd_col
      logic emit;       // the read in flight is a result
      logic emit_last;  // that result closes the row
   } dp_cmd_type;

endpackage

// ----- hdl/gasr_ctrl.sv -----
// Controller for the global alignment score row unit.
// Sequences load, row init, cell walk and row emit; drives gasr_datapath.
// Depends on gasr_pkg.
module gasr_ctrl #(
   parameter int MAX_A_LEN = 1024,
   parameter int MAX_B_LEN = 63,
   parameter int COL_W     = 6,
   parameter int AADDR_W   = 10,
   parameter int BADDR_W   = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [gasr_pkg::OP_W-1:0]   req_operation,
   input  logic [gasr_pkg::POS_W-1:0]  req_position,
   input  logic [gasr_pkg::ALEN_W-1:0] a_length,
   input  logic [gasr_pkg::BLEN_W-1:0] b_length,
   input  logic                        reverse_mode,
   output gasr_pkg::dp_cmd_type        cmd,
   output logic [COL_W-1:0]            col,
   output logic [COL_W-1:0]            rd_col,
   output logic [gasr_pkg::ALEN_W-1:0] row_idx,
   output logic [AADDR_W-1:0]          a_addr,
   output logic [BADDR_W-1:0]          b_addr
);

   gasr_pkg::state_type         state_ff, state_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [gasr_pkg::ALEN_W-1:0] row_ff, row_in;
   logic [gasr_pkg::ALEN_W-1:0] rows_ff, rows_in;
   logic [COL_W-1:0]            cols_ff, cols_in;
   logic                        rev_ff, rev_in;
   logic                        accept;
   logic [gasr_pkg::ALEN_W-1:0] a_idx;
   logic [COL_W-1:0]            b_idx;

   // Lengths clamped to the store sizes
   always_comb begin
      if (32'(a_length) > MAX_A_LEN) begin
         rows_in = gasr_pkg::ALEN_W'(MAX_A_LEN);
      end else begin
         rows_in = a_length;
      end
      if (32'(b_length) > MAX_B_LEN) begin
         cols_in = COL_W'(MAX_B_LEN);
      end else begin
         cols_in = COL_W'(b_length);
      end
      rev_in = reverse_mode;
   end

   assign busy    = (state_ff != gasr_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign col     = col_ff;
   assign row_idx = row_ff;

   // Store addresses; reverse mode counts from the end of each sequence
   always_comb begin
      a_idx  = rev_ff ? (rows_ff - row_ff) : (row_ff - 1'b1);
      b_idx  = rev_ff ? (cols_ff - rd_col) : (rd_col - 1'b1);
      a_addr = AADDR_W'(a_idx);
      b_addr = BADDR_W'(b_idx);
   end

   // State and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gasr_pkg::ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         rows_ff  <= '0;
         cols_ff  <= '0;
         rev_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (accept && req_operation == gasr_pkg::OP_COMPUTE) begin
            rows_ff <= rows_in;
            cols_ff <= cols_in;
            rev_ff  <= rev_in;
         end
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      cmd      = '0;
      rd_col   = col_ff;

      unique case (state_ff)
         gasr_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_operation)
                  gasr_pkg::OP_LOAD_A: begin
                     cmd.load_a = (32'(req_position) < MAX_A_LEN);
                  end
                  gasr_pkg::OP_LOAD_B: begin
                     cmd.load_b = (32'(req_position) < MAX_B_LEN);
                  end
                  gasr_pkg::OP_COMPUTE: begin
                     state_in = gasr_pkg::ST_INIT;
                     col_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Row 0: entry j holds -j
         gasr_pkg::ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (col_ff == cols_ff) begin
               col_in = '0;
               row_in = gasr_pkg::ALEN_W'(1);
               if (rows_ff == '0) begin
                  state_in = gasr_pkg::ST_EMIT;
               end else begin
                  state_in = gasr_pkg::ST_ROW;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end

         // Row open: seed column 0, fetch A symbol and first column
         gasr_pkg::ST_ROW: begin
            cmd.row_start = 1'b1;
            rd_col        = COL_W'(1);
            cmd.rd_en     = (cols_ff != '0);
            if (cols_ff == '0) begin
               if (row_ff == rows_ff) begin
                  state_in = gasr_pkg::ST_EMIT;
                  col_in   = '0;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               state_in = gasr_pkg::ST_CELL;
               col_in   = COL_W'(1);
            end
         end

         // One cell a cycle, prefetching the next column
         gasr_pkg::ST_CELL: begin
            cmd.cell_en = 1'b1;
            rd_col      = col_ff + 1'b1;
            cmd.rd_en   = (col_ff != cols_ff);
            if (col_ff == cols_ff) begin
               if (row_ff == rows_ff) begin
                  state_in = gasr_pkg::ST_EMIT;
                  col_in   = '0;
               end else begin
                  state_in = gasr_pkg::ST_ROW;
                  row_in   = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end

         // Read out the final row, one score a cycle
         gasr_pkg::ST_EMIT: begin
            cmd.rd_en     = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_last = (col_ff == cols_ff);
            if (col_ff == cols_ff) begin
               state_in = gasr_pkg::ST_IDLE;
               col_in   = '0;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end

         default: begin
            state_in = gasr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/gasr_datapath.sv -----
// Datapath for the global alignment score row unit.
// Sequence stores, score row memory, cell max unit and result register.
// Depends on gasr_pkg; driven by gasr_ctrl.
module gasr_datapath #(
   parameter int MAX_A_LEN = 1024,
   parameter int MAX_B_LEN = 63,
   parameter int COL_W     = 6,
   parameter int AADDR_W   = 10,
   parameter int BADDR_W   = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gasr_pkg::dp_cmd_type          cmd,
   input  logic [COL_W-1:0]              col,
   input  logic [COL_W-1:0]              rd_col,
   input  logic [gasr_pkg::ALEN_W-1:0]   row_idx,
   input  logic [AADDR_W-1:0]            a_addr,
   input  logic [BADDR_W-1:0]            b_addr,
   input  logic [gasr_pkg::POS_W-1:0]    req_position,
   input  logic [gasr_pkg::SYM_W-1:0]    req_symbol,
   output logic                          rsp_valid,
   output logic [gasr_pkg::COLUMN_W-1:0] rsp_column,
   output logic signed [gasr_pkg::RSP_W-1:0] rsp_score,
   output logic                          rsp_last
);

   localparam int ROW_DEPTH = MAX_B_LEN + 1;

   logic [gasr_pkg::SYM_W-1:0] a_mem [MAX_A_LEN];
   logic [gasr_pkg::SYM_W-1:0] b_mem [MAX_B_LEN];
   gasr_pkg::score_type        row_mem [ROW_DEPTH];

   logic [gasr_pkg::SYM_W-1:0] a_sym_ff;
   logic [gasr_pkg::SYM_W-1:0] b_sym_ff;
   gasr_pkg::score_type        row_rd_ff;
   gasr_pkg::score_type        left_ff, left_in;
   gasr_pkg::score_type        diag_ff, diag_in;
   logic                       emit_vld_ff;
   logic [COL_W-1:0]           emit_col_ff;
   logic                       emit_last_ff;

   gasr_pkg::score_type neg_row, neg_col;
   gasr_pkg::score_type cand_diag, cand_top, cand_left, best;
   gasr_pkg::score_type wr_data;
   logic [COL_W-1:0]    wr_addr;
   logic                wr_en;

   // Sequence stores
   always_ff @(posedge clock) begin
      if (cmd.load_a) begin
         a_mem[AADDR_W'(req_position)] <= req_symbol;
      end
      if (cmd.row_start) begin
         a_sym_ff <= a_mem[a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_b) begin
         b_mem[BADDR_W'(req_position)] <= req_symbol;
      end
      if (cmd.rd_en) begin
         b_sym_ff <= b_mem[b_addr];
      end
   end

   // Cell: max of diagonal + weight, top - 1, left - 1
   always_comb begin
      neg_row   = -$signed(gasr_pkg::SCORE_W'(row_idx));
      neg_col   = -$signed(gasr_pkg::SCORE_W'(col));
      cand_diag = (a_sym_ff == b_sym_ff) ? diag_ff + gasr_pkg::SCORE_ONE
                                         : diag_ff - gasr_pkg::SCORE_ONE;
      cand_top  = row_rd_ff - gasr_pkg::SCORE_ONE;
      cand_left = left_ff - gasr_pkg::SCORE_ONE;
      best      = cand_diag;
      if (cand_left > best) begin
         best = cand_left;
      end
      if (cand_top > best) begin
         best = cand_top;
      end
   end

   // Row memory write port
   always_comb begin
      wr_en   = cmd.init_wr || cmd.row_start || cmd.cell_en;
      wr_addr = col;
      wr_data = best;
      priority if (cmd.init_wr) begin
         wr_data = neg_col;
      end else if (cmd.row_start) begin
         wr_addr = '0;
         wr_data = neg_row;
      end else begin
         wr_data = best;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         row_rd_ff <= row_mem[rd_col];
      end
   end

   // Left and diagonal carries along the row
   always_comb begin
      left_in = left_ff;
      diag_in = diag_ff;
      priority if (cmd.row_start) begin
         left_in = neg_row;
         diag_in = neg_row + gasr_pkg::SCORE_ONE;
      end else if (cmd.cell_en) begin
         left_in = best;
         diag_in = row_rd_ff;
      end else begin
         left_in = left_ff;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      diag_ff <= diag_in;
   end

   // Result stage, aligned with the registered row read
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_vld_ff <= 1'b0;
      end else begin
         emit_vld_ff <= cmd.emit;
      end
      emit_col_ff  <= col;
      emit_last_ff <= cmd.emit_last;
   end

   assign rsp_valid  = emit_vld_ff;
   assign rsp_column = gasr_pkg::COLUMN_W'(emit_col_ff);
   assign rsp_last   = emit_last_ff;

   // Saturate to the 12-bit result
   always_comb begin
      priority if (row_rd_ff > gasr_pkg::RSP_MAX) begin
         rsp_score = gasr_pkg::RSP_W'(gasr_pkg::RSP_MAX);
      end else if (row_rd_ff < gasr_pkg::RSP_MIN) begin
         rsp_score = gasr_pkg::RSP_W'(gasr_pkg::RSP_MIN);
      end else begin
         rsp_score = gasr_pkg::RSP_W'(row_rd_ff);
      end
   end

endmodule

// ----- hdl/global_alignment_score_row_unit.sv -----
// Global alignment score row unit: linear-space score table, final row out.
// A compute request writes the initial row, then opens each row and computes
// one table cell a cycle along it from the single row memory port pair, then
// reads out the final row. Results cannot be stalled. Synchronous reset clears
// control and the length registers; sequence stores and the score row stay
// undefined until written.
module global_alignment_score_row_unit #(
   parameter int MAX_A_LEN = 1024,
   parameter int MAX_B_LEN = 63
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gasr_pkg::OP_W-1:0]         req_operation,
   input  logic [gasr_pkg::POS_W-1:0]        req_position,
   input  logic [gasr_pkg::SYM_W-1:0]        req_symbol,
   output logic                              rsp_valid,
   output logic [gasr_pkg::COLUMN_W-1:0]     rsp_column,
   output logic signed [gasr_pkg::RSP_W-1:0] rsp_score,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [gasr_pkg::CSR_W-1:0]        csr_data
);

   localparam int COL_W   = $clog2(MAX_B_LEN + 1);
   localparam int AADDR_W = (MAX_A_LEN > 1) ? $clog2(MAX_A_LEN) : 1;
   localparam int BADDR_W = (MAX_B_LEN > 1) ? $clog2(MAX_B_LEN) : 1;

   logic [gasr_pkg::ALEN_W-1:0] a_length_ff;
   logic [gasr_pkg::BLEN_W-1:0] b_length_ff;
   logic                        reverse_mode_ff;

   gasr_pkg::dp_cmd_type        cmd;
   logic [COL_W-1:0]            col;
   logic [COL_W-1:0]            rd_col;
   logic [gasr_pkg::ALEN_W-1:0] row_idx;
   logic [AADDR_W-1:0]          a_addr;
   logic [BADDR_W-1:0]          b_addr;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_length_ff     <= '0;
         b_length_ff     <= '0;
         reverse_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gasr_pkg::CSR_A_LENGTH: begin
               a_length_ff <= gasr_pkg::ALEN_W'(csr_data);
            end
            gasr_pkg::CSR_B_LENGTH: begin
               b_length_ff <= gasr_pkg::BLEN_W'(csr_data);
            end
            gasr_pkg::CSR_REVERSE_MODE: begin
               reverse_mode_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   gasr_ctrl #(
      .MAX_A_LEN (MAX_A_LEN),
      .MAX_B_LEN (MAX_B_LEN),
      .COL_W     (COL_W),
      .AADDR_W   (AADDR_W),
      .BADDR_W   (BADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_position  (req_position),
      .a_length      (a_length_ff),
      .b_length      (b_length_ff),
      .reverse_mode  (reverse_mode_ff),
      .cmd           (cmd),
      .col           (col),
      .rd_col        (rd_col),
      .row_idx       (row_idx),
      .a_addr        (a_addr),
      .b_addr        (b_addr)
   );

   gasr_datapath #(
      .MAX_A_LEN (MAX_A_LEN),
      .MAX_B_LEN (MAX_B_LEN),
      .COL_W     (COL_W),
      .AADDR_W   (AADDR_W),
      .BADDR_W   (BADDR_W)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .col          (col),
      .rd_col       (rd_col),
      .row_idx      (row_idx),
      .a_addr       (a_addr),
      .b_addr       (b_addr),
      .req_position (req_position),
      .req_symbol   (req_symbol),
      .rsp_valid    (rsp_valid),
      .rsp_column   (rsp_column),
      .rsp_score    (rsp_score),
      .rsp_last     (rsp_last)
   );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Testbench for global_alignment_score_row_unit: random and directed load and compute
// requests, with a built-in alignment row predictor that checks every emitted score.
// Depends on gasr_pkg and the global_alignment_score_row_unit RTL.
module tb;

   localparam int A_DEPTH = 1024;
   localparam int B_DEPTH = 63;
   // Entries of A written up front; A lengths stay within them
   localparam int A_FILL = 16;
   localparam logic [gasr_pkg::OP_W-1:0] OP_UNUSED  = 2'd3;
   localparam logic [1:0]                CSR_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 16;

   typedef struct packed {
      logic [gasr_pkg::OP_W-1:0]  op;
      logic [gasr_pkg::POS_W-1:0] pos;
      logic [gasr_pkg::SYM_W-1:0] sym;
   } request_type;

   typedef struct packed {
      logic [gasr_pkg::COLUMN_W-1:0]     column;
      logic signed [gasr_pkg::RSP_W-1:0] score;
      logic                              last;
   } row_score_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [gasr_pkg::OP_W-1:0]  req_operation = '0;
   logic [gasr_pkg::POS_W-1:0] req_position = '0;
   logic [gasr_pkg::SYM_W-1:0] req_symbol = '0;
   logic rsp_valid;
   logic [gasr_pkg::COLUMN_W-1:0] rsp_column;
   logic signed [gasr_pkg::RSP_W-1:0] rsp_score;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [gasr_pkg::CSR_W-1:0] csr_data = '0;

   // Requests waiting for the driver and scores waiting for the DUT
   request_type   request_q[$];
   row_score_type pending_scores[$];
   int unaccepted = 0;
   int gap_left = 0;
   int idle_pct = 0;
   int error_count = 0;
   int n_computes = 0;
   int n_loads = 0;
   int n_scores = 0;
   int n_settings = 0;

   // Predictor copy of the registers and sequence stores
   logic [gasr_pkg::ALEN_W-1:0] cfg_a_len = '0;
   logic [gasr_pkg::BLEN_W-1:0] cfg_b_len = '0;
   logic                        cfg_reverse = 1'b0;
   logic [gasr_pkg::SYM_W-1:0]  a_store [0:A_DEPTH-1];
   logic [gasr_pkg::SYM_W-1:0]  b_store [0:B_DEPTH-1];

   global_alignment_score_row_unit #(
      .MAX_A_LEN(A_DEPTH),
      .MAX_B_LEN(B_DEPTH)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_operation(req_operation),
      .req_position (req_position),
      .req_symbol   (req_symbol),
      .rsp_valid    (rsp_valid),
      .rsp_column   (rsp_column),
      .rsp_score    (rsp_score),
      .rsp_last     (rsp_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Mostly no gap, sometimes short, rarely long
   function automatic int pick_gap();
      int r;
      if ($urandom_range(0, 99) >= idle_pct) return 0;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Small alphabet gives plenty of matches; full bytes now and then
   function automatic logic [gasr_pkg::SYM_W-1:0] pick_symbol();
      case ($urandom_range(0, 19))
         0, 1, 2, 3: return 8'h41;
         4, 5, 6, 7: return 8'h43;
         8, 9, 10, 11: return 8'h47;
         12, 13, 14, 15: return 8'h54;
         default: return gasr_pkg::SYM_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Global alignment of A against B, two rows kept, final row queued as scores
   task automatic align_final_row();
      int rows, cols, ai, bj, w, s, diag, top, left;
      int prev_row [0:B_DEPTH];
      int cur_row [0:B_DEPTH];
      row_score_type r;
      rows = (int'(cfg_a_len) > A_DEPTH) ? A_DEPTH : int'(cfg_a_len);
      cols = (int'(cfg_b_len) > B_DEPTH) ? B_DEPTH : int'(cfg_b_len);
      for (int j = 0; j <= cols; j++) prev_row[j] = -j;
      for (int i = 1; i <= rows; i++) begin
         cur_row[0] = -i;
         for (int j = 1; j <= cols; j++) begin
            ai = cfg_reverse ? rows - i : i - 1;
            bj = cfg_reverse ? cols - j : j - 1;
            w = (a_store[ai] == b_store[bj]) ? 1 : -1;
            diag = prev_row[j-1] + w;
            top = prev_row[j] - 1;
            left = cur_row[j-1] - 1;
            s = diag;
            if (left > s) s = left;
            if (top > s) s = top;
            cur_row[j] = s;
         end
         for (int j = 0; j <= cols; j++) prev_row[j] = cur_row[j];
      end
      for (int j = 0; j <= cols; j++) begin
         s = prev_row[j];
         if (s > 2047) s = 2047;
         if (s < -2048) s = -2048;
         r.column = gasr_pkg::COLUMN_W'(j);
         r.score = gasr_pkg::RSP_W'(s);
         r.last = (j == cols);
         pending_scores.push_back(r);
      end
   endtask

   task automatic predict_request(input request_type q);
      case (q.op)
         gasr_pkg::OP_LOAD_A: begin
            n_loads++;
            if (int'(q.pos) < A_DEPTH) a_store[q.pos] = q.sym;
         end
         gasr_pkg::OP_LOAD_B: begin
            n_loads++;
            if (int'(q.pos) < B_DEPTH) b_store[q.pos[5:0]] = q.sym;
         end
         gasr_pkg::OP_COMPUTE: begin
            n_computes++;
            align_final_row();
         end
         default: ;
      endcase
   endtask

   // Driver: one request at a time, random gaps between requests
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (!(start && busy)) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
         end else if (request_q.size() != 0) begin
            request_type q;
            q = request_q.pop_front();
            req_operation <= q.op;
            req_position <= q.pos;
            req_symbol <= q.sym;
            start <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: register writes, accepted requests and emitted scores
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gasr_pkg::CSR_A_LENGTH:     cfg_a_len = csr_data[gasr_pkg::ALEN_W-1:0];
               gasr_pkg::CSR_B_LENGTH:     cfg_b_len = csr_data[gasr_pkg::BLEN_W-1:0];
               gasr_pkg::CSR_REVERSE_MODE: cfg_reverse = csr_data[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            predict_request('{req_operation, req_position, req_symbol});
            unaccepted--;
         end
         if (rsp_valid) begin
            row_score_type r;
            n_scores++;
            if (pending_scores.size() == 0) begin
               error_count++;
               $display("%0t ns: unexpected score, expected none,", $time,
                        " actual column %0d score %0d last %0d",
                        rsp_column, rsp_score, rsp_last);
            end else begin
               r = pending_scores.pop_front();
               if (rsp_column !== r.column) begin
                  error_count++;
                  $display("%0t ns: column mismatch, expected %0d, actual %0d",
                           $time, r.column, rsp_column);
               end
               if (rsp_score !== r.score) begin
                  error_count++;
                  $display("%0t ns: score mismatch at column %0d, expected %0d, actual %0d",
                           $time, r.column, r.score, rsp_score);
               end
               if (rsp_last !== r.last) begin
                  error_count++;
                  $display("%0t ns: last mismatch at column %0d, expected %0d, actual %0d",
                           $time, r.column, r.last, rsp_last);
               end
            end
         end
      end
   end

   task automatic queue_request(input logic [1:0] op, input int pos, input logic [7:0] sym);
      request_q.push_back('{op, gasr_pkg::POS_W'(pos), sym});
      unaccepted++;
   endtask

   task automatic write_csr(input logic [1:0] index,
                            input logic [gasr_pkg::CSR_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_lengths(input int a_val, input int b_val, input int rev_val);
      write_csr(gasr_pkg::CSR_A_LENGTH, gasr_pkg::CSR_W'(a_val));
      write_csr(gasr_pkg::CSR_B_LENGTH, gasr_pkg::CSR_W'(b_val));
      write_csr(gasr_pkg::CSR_REVERSE_MODE, gasr_pkg::CSR_W'(rev_val));
      n_settings++;
   endtask

   // Wait until every request is taken, every score seen and the DUT is idle
   task automatic drain_block();
      do @(posedge clock);
      while (unaccepted != 0 || start || busy || pending_scores.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      int random_count;
      int a_val;
      int b_val;
      int rev_val;
      int pos;
      int kind;
      random_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset lengths: empty A against empty B
      queue_request(gasr_pkg::OP_COMPUTE, 0, 8'h00);
      // Unused operation and out-of-range B positions are ignored
      queue_request(OP_UNUSED, 1023, 8'hFF);
      queue_request(gasr_pkg::OP_LOAD_B, B_DEPTH, 8'h00);
      queue_request(gasr_pkg::OP_LOAD_B, 1023, 8'hFF);
      drain_block();

      // Fill the A entries in use and all of B so no compute reads an unwritten entry
      idle_pct = 20;
      queue_request(gasr_pkg::OP_LOAD_A, 0, 8'h00);
      for (int p = 1; p < A_FILL - 1; p++) begin
         queue_request(gasr_pkg::OP_LOAD_A, p, pick_symbol());
      end
      queue_request(gasr_pkg::OP_LOAD_A, A_FILL - 1, 8'hFF);
      queue_request(gasr_pkg::OP_LOAD_A, A_DEPTH - 1, 8'hFF);
      for (int p = 0; p < B_DEPTH; p++) queue_request(gasr_pkg::OP_LOAD_B, p, pick_symbol());
      drain_block();

      // Unused register index changes nothing; empty A gives the initial row
      write_csr(CSR_UNUSED, '1);
      set_lengths(0, 63, 0);
      queue_request(gasr_pkg::OP_COMPUTE, 1023, 8'hFF);
      drain_block();

      // Empty B, with upper data bits that the register drops
      set_lengths(5, 11'h7C0, 11'h7FE);
      queue_request(gasr_pkg::OP_COMPUTE, 0, 8'h00);
      drain_block();

      // Single cell: match then mismatch, reverse mode
      set_lengths(1, 1, 1);
      queue_request(gasr_pkg::OP_LOAD_A, 0, 8'h41);
      queue_request(gasr_pkg::OP_LOAD_B, 0, 8'h41);
      queue_request(gasr_pkg::OP_COMPUTE, 0, 8'h00);
      queue_request(gasr_pkg::OP_LOAD_B, 0, 8'h54);
      queue_request(gasr_pkg::OP_COMPUTE, 0, 8'h00);
      drain_block();

      // All filled rows against the widest row, forward then reverse
      idle_pct = 0;
      set_lengths(A_FILL, B_DEPTH, 0);
      queue_request(gasr_pkg::OP_COMPUTE, 0, 8'h00);
      drain_block();
      set_lengths(A_FILL, B_DEPTH, 1);
      queue_request(gasr_pkg::OP_COMPUTE, 0, 8'h00);
      drain_block();

      // Random phases: new lengths, a few loads, unused and compute requests, then a final compute
      while (random_count < RANDOM_REQUESTS) begin
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 20;
            default: idle_pct = 50;
         endcase
         kind = $urandom_range(0, 99);
         if (kind < 10) a_val = 0;
         else a_val = $urandom_range(1, A_FILL);
         b_val = $urandom_range(0, 63);
         if ($urandom_range(0, 4) == 0) begin
            b_val = b_val | ($urandom_range(0, 31) << gasr_pkg::BLEN_W);
         end
         rev_val = $urandom_range(0, 1);
         if ($urandom_range(0, 4) == 0) rev_val = rev_val | ($urandom_range(0, 1023) << 1);
         set_lengths(a_val, b_val, rev_val);
         repeat ($urandom_range(2, 7)) begin
            kind = $urandom_range(0, 99);
            pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 47) : $urandom_range(0, 1023);
            if (kind < 50) begin
               queue_request(gasr_pkg::OP_LOAD_A, pos, pick_symbol());
               random_count++;
            end else if (kind < 85) begin
               if ($urandom_range(0, 4) != 0) pos = $urandom_range(0, B_DEPTH - 1);
               queue_request(gasr_pkg::OP_LOAD_B, pos, pick_symbol());
               if (pos < B_DEPTH) random_count++;
            end else if (kind < 92) begin
               queue_request(OP_UNUSED, $urandom_range(0, 1023),
                             gasr_pkg::SYM_W'($urandom_range(0, 255)));
            end else begin
               queue_request(gasr_pkg::OP_COMPUTE, $urandom_range(0, 1023),
                             gasr_pkg::SYM_W'($urandom_range(0, 255)));
               random_count++;
            end
         end
         queue_request(gasr_pkg::OP_COMPUTE, $urandom_range(0, 1023),
                       gasr_pkg::SYM_W'($urandom_range(0, 255)));
         random_count++;
         drain_block();
      end

      repeat (20) @(posedge clock);
      $display("Ran %0d compute and %0d load requests over %0d length settings.",
               n_computes, n_loads, n_settings);
      $display("Checked %0d emitted scores, %0d errors.", n_scores, error_count);
      if (error_count == 0) begin
         $display("global_alignment_score_row_unit test passed");
      end else begin
         $display("global_alignment_score_row_unit test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20000000;
      $display("Timeout: %0d requests still queued, %0d scores outstanding",
               unaccepted, pending_scores.size());
      $display("global_alignment_score_row_unit test failed");
      $finish;
   end

endmodule
